### src/gsqm_pkg.sv
// Package with shared types, constants and codes for the signal quality monitor.
`timescale 1ns / 1ps
package gsqm_pkg;

  localparam int WINDOW_DEFAULT = 300;
  localparam int TIMER_W = 22;
  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 22;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_CNO_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AGC_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_JAM_TRIGGER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRACE_MS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AGC_CHECKS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ANALYSIS = 3'd7;

  // Item operation codes.
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_INC_START = 2'd2;
  localparam logic [1:0] OP_INC_END = 2'd3;

  // One item as it travels from the front to the back through the queue.
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] cno;
    logic signed [7:0] agc;
    logic signed [8:0] jam_level;
    logic fix_valid;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_RD,
    ST_PUSH_WR,
    ST_DIV,
    ST_CHECK,
    ST_OUT
  } back_state_t;

endpackage

### src/gnss_signal_quality_monitor_top.sv
// Top level of the GNSS signal quality monitor.
//
// channel | direction | handshake           | payload
// in      | input     | in_valid, in_stall  | opcode, cno, agc, jam_level, fix_valid
// out     | output    | out_valid, out_stall| averages, deviations, alarms, events
// cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// A sample passes, once the back part takes it, through the window memory read and
// write, a divider start, three serial divisions (each a busy phase ending in a done
// strobe, only the done strobe for an empty window), a check state and the output
// state, where its result is offered. Ticks and incident events go from the take
// straight to the output state. Reset is synchronous; no clearing pass is needed.
// A two-item queue takes input while the back part works or waits on out_stall.
`timescale 1ns / 1ps
module gnss_signal_quality_monitor_top #(
  parameter int WINDOW = gsqm_pkg::WINDOW_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] opcode,
  input  logic [7:0] cno,
  input  logic signed [7:0] agc,
  input  logic signed [8:0] jam_level,
  input  logic fix_valid,
  output logic out_valid,
  input  logic out_stall,
  output logic [7:0] avg_cno,
  output logic [6:0] avg_agc,
  output logic [7:0] avg_jam,
  output logic [7:0] cno_dev,
  output logic [6:0] agc_dev,
  output logic cno_alarm,
  output logic agc_alarm,
  output logic jam_alarm,
  output logic raised,
  output logic all_clear,
  output logic record_req,
  input  logic cfg_we,
  input  logic [gsqm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gsqm_pkg::CFG_DATA_W-1:0] cfg_data
);

  gsqm_pkg::item_t in_item;
  gsqm_pkg::item_t q_item;
  logic q_valid;
  logic q_take;

  logic [7:0] cno_limit;
  logic [6:0] agc_limit;
  logic [7:0] jam_trigger;
  logic [21:0] filter_ms;
  logic [21:0] grace_ms;
  logic agc_checks_on;
  logic record_on_alarm;
  logic analysis_on;

  assign in_item = '{opcode: opcode, cno: cno, agc: agc, jam_level: jam_level,
                     fix_valid: fix_valid};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cno_limit <= '0;
      agc_limit <= '0;
      jam_trigger <= 8'd255;
      filter_ms <= '0;
      grace_ms <= '0;
      agc_checks_on <= 1'b0;
      record_on_alarm <= 1'b0;
      analysis_on <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        gsqm_pkg::REG_CNO_LIMIT: cno_limit <= cfg_data[7:0];
        gsqm_pkg::REG_AGC_LIMIT: agc_limit <= cfg_data[6:0];
        gsqm_pkg::REG_JAM_TRIGGER: jam_trigger <= cfg_data[7:0];
        gsqm_pkg::REG_FILTER_MS: filter_ms <= cfg_data[21:0];
        gsqm_pkg::REG_GRACE_MS: grace_ms <= cfg_data[21:0];
        gsqm_pkg::REG_AGC_CHECKS: agc_checks_on <= cfg_data[0];
        gsqm_pkg::REG_RECORD: record_on_alarm <= cfg_data[0];
        gsqm_pkg::REG_ANALYSIS: analysis_on <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  gsqm_front u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .q_valid(q_valid),
    .q_take(q_take),
    .q_item(q_item)
  );

  gsqm_back #(.WINDOW(WINDOW)) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_take(q_take),
    .q_item(q_item),
    .cno_limit(cno_limit),
    .agc_limit(agc_limit),
    .jam_trigger(jam_trigger),
    .filter_ms(filter_ms),
    .grace_ms(grace_ms),
    .agc_checks_on(agc_checks_on),
    .record_on_alarm(record_on_alarm),
    .analysis_on(analysis_on),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .avg_cno(avg_cno),
    .avg_agc(avg_agc),
    .avg_jam(avg_jam),
    .cno_dev(cno_dev),
    .agc_dev(agc_dev),
    .cno_alarm(cno_alarm),
    .agc_alarm(agc_alarm),
    .jam_alarm(jam_alarm),
    .raised(raised),
    .all_clear(all_clear),
    .record_req(record_req)
  );

`ifndef SYNTH
  // A raise event always shows at least one active alarm.
  a_raise_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && raised |-> (cno_alarm || agc_alarm || jam_alarm))
    else $error("raise without active alarm");

  // A stalled result item stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({avg_cno, avg_agc, avg_jam,
      cno_dev, agc_dev, cno_alarm, agc_alarm, jam_alarm, raised, all_clear,
      record_req}))
    else $error("stalled result item changed");
`endif

endmodule

### src/gsqm_front.sv
// Front part: accepts items into a short queue for the back part.
`timescale 1ns / 1ps
module gsqm_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  gsqm_pkg::item_t in_item,
  output logic q_valid,
  input  logic q_take,
  output gsqm_pkg::item_t q_item
);

  localparam int QDEPTH = 2;

  gsqm_pkg::item_t slots [QDEPTH];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] fill;
  logic push;
  logic pop;

  assign in_stall = (fill == 2'(QDEPTH));
  assign push = in_valid && !in_stall;
  assign pop = q_take && q_valid;
  assign q_valid = (fill != 2'd0);
  assign q_item = slots[rd_ptr];

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_item;
  end

endmodule

### src/gsqm_divider.sv
// Serial restoring divider for window sum over count, one quotient bit a cycle.
`timescale 1ns / 1ps
module gsqm_divider #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 9
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic busy,
  output logic done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q;
  logic [DEN_W:0] rem;
  logic [DEN_W-1:0] d;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0] trial;
  logic [DEN_W:0] shifted;

  assign shifted = {rem[DEN_W-1:0], q[NUM_W-1]};
  assign trial = shifted - {1'b0, d};
  assign quo = q;

  // Shift-subtract iterations; a zero divisor gives zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= (den != '0);
        done <= (den == '0);
        cnt <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= (den == '0) ? '0 : num;
      rem <= '0;
      d <= den;
    end else if (busy) begin
      if (!trial[DEN_W]) begin
        rem <= trial;
        q <= {q[NUM_W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        q <= {q[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

### src/gsqm_back.sv
// Back part: window updates, averages, deviations and alarm qualification.
`timescale 1ns / 1ps
module gsqm_back #(
  parameter int WINDOW = gsqm_pkg::WINDOW_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_take,
  input  gsqm_pkg::item_t q_item,
  input  logic [7:0] cno_limit,
  input  logic [6:0] agc_limit,
  input  logic [7:0] jam_trigger,
  input  logic [21:0] filter_ms,
  input  logic [21:0] grace_ms,
  input  logic agc_checks_on,
  input  logic record_on_alarm,
  input  logic analysis_on,
  output logic out_valid,
  input  logic out_stall,
  output logic [7:0] avg_cno,
  output logic [6:0] avg_agc,
  output logic [7:0] avg_jam,
  output logic [7:0] cno_dev,
  output logic [6:0] agc_dev,
  output logic cno_alarm,
  output logic agc_alarm,
  output logic jam_alarm,
  output logic raised,
  output logic all_clear,
  output logic record_req
);

  localparam int DEPTH = WINDOW + 1;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 8;
  localparam int TW = gsqm_pkg::TIMER_W;

  gsqm_pkg::back_state_t state;
  gsqm_pkg::back_state_t state_next;
  gsqm_pkg::item_t cur;

  logic [7:0] cno_mem [DEPTH];
  logic [6:0] agc_mem [DEPTH];
  logic [7:0] jam_mem [DEPTH];
  logic [7:0] cno_old;
  logic [6:0] agc_old;
  logic [7:0] jam_old;

  logic [SUM_W-1:0] sums [3];
  logic [CNT_W-1:0] counts [3];
  logic [PTR_W-1:0] heads [3];
  logic [2:0] flags;
  logic [2:0] qvalid;
  logic [TW-1:0] qelapsed [3];
  logic incident;
  logic grace_valid;
  logic [TW-1:0] grace_elapsed;

  logic pause;
  logic [2:0] do_push;
  logic [1:0] div_idx;
  logic [1:0] div_sel;
  logic div_start;
  logic div_busy;
  logic div_done;
  logic [SUM_W-1:0] div_quo;
  logic [7:0] avgs [3];

  // Handshake with the queue and the output register.
  assign q_take = (state == gsqm_pkg::ST_IDLE);
  assign out_valid = (state == gsqm_pkg::ST_OUT);
  assign cno_alarm = flags[0];
  assign agc_alarm = flags[1];
  assign jam_alarm = flags[2];
  assign avg_cno = avgs[0];
  assign avg_agc = avgs[1][6:0];
  assign avg_jam = avgs[2];

  // Pause decision for the current sample.
  assign pause = incident || (grace_valid && (grace_elapsed < grace_ms));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      gsqm_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_next = (q_item.opcode == gsqm_pkg::OP_SAMPLE) ?
                       gsqm_pkg::ST_PUSH_RD : gsqm_pkg::ST_OUT;
        end
      end
      gsqm_pkg::ST_PUSH_RD: state_next = gsqm_pkg::ST_PUSH_WR;
      gsqm_pkg::ST_PUSH_WR: state_next = gsqm_pkg::ST_DIV;
      gsqm_pkg::ST_DIV: begin
        if (div_done && div_idx == 2'd2) state_next = gsqm_pkg::ST_CHECK;
      end
      gsqm_pkg::ST_CHECK: state_next = gsqm_pkg::ST_OUT;
      gsqm_pkg::ST_OUT: begin
        if (!out_stall) state_next = gsqm_pkg::ST_IDLE;
      end
      default: state_next = gsqm_pkg::ST_IDLE;
    endcase
  end

  // Divider start control. The first division starts once the window sums
  // have settled; each later one starts as the previous one finishes.
  always_comb begin
    div_start = 1'b0;
    case (state)
      gsqm_pkg::ST_DIV: begin
        div_start = (div_idx == 2'd0 && !div_busy && !div_done) ||
                    (div_done && div_idx != 2'd2);
      end
      default: div_start = 1'b0;
    endcase
  end

  // Window whose sum and count feed the divider.
  assign div_sel = (div_done && div_idx != 2'd2) ? div_idx + 2'd1 : div_idx;

  always_ff @(posedge clk) begin
    if (rst) state <= gsqm_pkg::ST_IDLE;
    else state <= state_next;
  end

  gsqm_divider #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .num(sums[div_sel]),
    .den(counts[div_sel]),
    .busy(div_busy),
    .done(div_done),
    .quo(div_quo)
  );

  // Window memories: read the oldest entry, then overwrite it.
  always_ff @(posedge clk) begin
    if (state == gsqm_pkg::ST_PUSH_RD) begin
      cno_old <= cno_mem[heads[0]];
      agc_old <= agc_mem[heads[1]];
      jam_old <= jam_mem[heads[2]];
    end
    if (state == gsqm_pkg::ST_PUSH_WR) begin
      if (do_push[0]) cno_mem[heads[0]] <= cur.cno;
      if (do_push[1]) agc_mem[heads[1]] <= cur.agc[6:0];
      if (do_push[2]) jam_mem[heads[2]] <= cur.jam_level[7:0];
    end
  end

  // Working item, deviations and events.
  logic [8:0] dc_diff;
  logic [8:0] da_diff;
  logic [7:0] cdev_w;
  logic [7:0] adev_full;
  logic [2:0] cond;
  logic [2:0] chk_en;

  always_comb begin
    dc_diff = {1'b0, cur.cno} - {1'b0, avgs[0]};
    if (dc_diff[8]) dc_diff = -dc_diff;
    cdev_w = dc_diff[7:0];
    da_diff = {cur.agc[7], cur.agc} - {1'b0, avgs[1]};
    if (da_diff[8]) da_diff = -da_diff;
    adev_full = da_diff[7:0];
    cond[0] = (cno_limit != 8'd0) && (cdev_w > cno_limit);
    cond[1] = (agc_limit != 7'd0) && (adev_full > {1'b0, agc_limit});
    cond[2] = !cur.jam_level[8] && (cur.jam_level[7:0] > jam_trigger);
    chk_en = {agc_checks_on, agc_checks_on, 1'b1};
  end

  always_ff @(posedge clk) begin
    if (state == gsqm_pkg::ST_IDLE && q_valid) cur <= q_item;
  end

  // Control and bookkeeping state.
  always_ff @(posedge clk) begin
    logic [2:0] f;
    logic [2:0] qv;
    logic rs;
    logic cl;
    logic rr;
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        sums[k] <= '0;
        counts[k] <= '0;
        heads[k] <= '0;
        qelapsed[k] <= '0;
      end
      flags <= '0;
      qvalid <= '0;
      incident <= 1'b0;
      grace_valid <= 1'b0;
      grace_elapsed <= '0;
      do_push <= '0;
      div_idx <= '0;
      raised <= 1'b0;
      all_clear <= 1'b0;
      record_req <= 1'b0;
      cno_dev <= '0;
      agc_dev <= '0;
      for (int k = 0; k < 3; k++) avgs[k] <= '0;
    end else begin
      case (state)
        gsqm_pkg::ST_IDLE: begin
          raised <= 1'b0;
          all_clear <= 1'b0;
          record_req <= 1'b0;
          cno_dev <= '0;
          agc_dev <= '0;
          if (q_valid) begin
            case (q_item.opcode)
              gsqm_pkg::OP_TICK: begin
                for (int k = 0; k < 3; k++)
                  if (qvalid[k] && qelapsed[k] != gsqm_pkg::TIMER_MAX)
                    qelapsed[k] <= qelapsed[k] + 1'b1;
                if (grace_valid && grace_elapsed != gsqm_pkg::TIMER_MAX)
                  grace_elapsed <= grace_elapsed + 1'b1;
              end
              gsqm_pkg::OP_INC_START: begin
                incident <= 1'b1;
                grace_valid <= 1'b0;
              end
              gsqm_pkg::OP_INC_END: begin
                incident <= 1'b0;
                grace_valid <= 1'b1;
                grace_elapsed <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        gsqm_pkg::ST_PUSH_RD: begin
          if (!incident && grace_valid && !(grace_elapsed < grace_ms))
            grace_valid <= 1'b0;
          do_push[0] <= !pause && (cur.cno != 8'd0);
          do_push[1] <= !pause && !cur.agc[7] && (cur.agc != 8'sd0);
          do_push[2] <= !cur.jam_level[8];
        end
        gsqm_pkg::ST_PUSH_WR: begin
          div_idx <= 2'd0;
          for (int k = 0; k < 3; k++) begin
            if (do_push[k]) begin
              logic [7:0] nv;
              logic [7:0] ov;
              case (k)
                0: begin nv = cur.cno; ov = cno_old; end
                1: begin nv = {1'b0, cur.agc[6:0]}; ov = {1'b0, agc_old}; end
                default: begin nv = cur.jam_level[7:0]; ov = jam_old; end
              endcase
              if (counts[k] >= CNT_W'(DEPTH)) begin
                sums[k] <= sums[k] - SUM_W'(ov) + SUM_W'(nv);
              end else begin
                sums[k] <= sums[k] + SUM_W'(nv);
                counts[k] <= counts[k] + 1'b1;
              end
              heads[k] <= (heads[k] == PTR_W'(DEPTH - 1)) ? '0 : heads[k] + 1'b1;
            end
          end
        end
        gsqm_pkg::ST_DIV: begin
          if (div_done) begin
            avgs[div_idx] <= div_quo[7:0];
            if (div_idx != 2'd2) div_idx <= div_idx + 2'd1;
          end
        end
        gsqm_pkg::ST_CHECK: begin
          if (analysis_on) begin
            cno_dev <= cdev_w;
            agc_dev <= adev_full[7] ? 7'd127 : adev_full[6:0];
            f = flags;
            qv = qvalid;
            rs = 1'b0;
            cl = 1'b0;
            rr = 1'b0;
            for (int k = 0; k < 3; k++) begin
              if (chk_en[k] && cur.fix_valid) begin
                if (cond[k]) begin
                  if (!f[k] && !qv[k]) begin
                    qv[k] = 1'b1;
                    qelapsed[k] <= '0;
                  end else if (!f[k] && qelapsed[k] > filter_ms) begin
                    f[k] = 1'b1;
                    qv[k] = 1'b0;
                    rs = 1'b1;
                  end
                  if (record_on_alarm) rr = 1'b1;
                end else if (f[k]) begin
                  f[k] = 1'b0;
                  if (f == 3'b000) cl = 1'b1;
                end else if (qv[k]) begin
                  qv[k] = 1'b0;
                end
              end
            end
            flags <= f;
            qvalid <= qv;
            raised <= rs;
            all_clear <= cl;
            record_req <= rr;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
